// ===== hw/rtl/cioa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cioa_pkg - CAN id ownership arbiter package
// Shared types, codes and reset constants for the arbiter and its parts.
// ----------------------------------------------------------------------------
package cioa_pkg;

  // Number of slot id registers in the register map
  localparam int unsigned NUM_ID_REGS = 5;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  // Reset values of the configuration registers
  localparam logic [TICKS_W-1:0] BOOT_LISTEN_RESET = 16'd150;
  localparam logic [TICKS_W-1:0] SILENCE_TOUT_RESET = 16'd50;
  localparam logic [ID_W-1:0] SLOT_ID_RESET [NUM_ID_REGS] = '{
    11'h221, 11'h2D1, 11'h321, 11'h3A1, 11'h545
  };

  // Transaction operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Emulation modes; the unused code behaves as automatic
  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_ALWAYS = 2'd1,
    MODE_NEVER  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_BOOT  = 3'd1,
    REG_TOUT  = 3'd2,
    REG_SLOT0 = 3'd3,
    REG_SLOT1 = 3'd4,
    REG_SLOT2 = 3'd5,
    REG_SLOT3 = 3'd6,
    REG_SLOT4 = 3'd7
  } reg_idx_e;

  // Shared unit operations
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_EQ,
    ALU_LT,
    ALU_GT
  } alu_op_e;

  // Operand pairs fed to the shared unit
  typedef enum logic [2:0] {
    SRC_TICK_ONE,
    SRC_ID_SCAN,
    SRC_TICK_BOOT,
    SRC_TICK_HEARD,
    SRC_ELAP_TOUT
  } src_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_BOOT,
    ST_ELAP,
    ST_TOUT,
    ST_DONE
  } state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] can_id;
    logic [2:0]      slot;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic       may_transmit;
    logic       slot_matched;
    logic [2:0] matched_slot;
    logic [4:0] active_mask;
  } rsp_t;

  // Controls from sequencer to datapath
  typedef struct packed {
    logic    busy;
    logic    done;
    logic    capture;
    alu_op_e alu_op;
    src_e    src;
    logic    tick_we;
    logic    scan_en;
    logic    boot_we;
    logic    elap_we;
    logic    may_we;
  } ctl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic start;
    op_e  op;
    logic slot_ok;
    logic scan_last;
    logic hit;
  } sts_t;

endpackage

// ===== hw/rtl/cioa_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cioa_alu - shared arithmetic and compare unit
// One adder/subtractor/comparator reused by every step of the sequencer.
// ----------------------------------------------------------------------------
module cioa_alu
  import cioa_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output logic         flag_o
);

  always_comb begin
    res_o  = '0;
    flag_o = 1'b0;
    case (op_i)
      ALU_ADD: res_o  = a_i + b_i;
      ALU_SUB: res_o  = a_i - b_i;
      ALU_EQ:  flag_o = (a_i == b_i);
      ALU_LT:  flag_o = (a_i < b_i);
      ALU_GT:  flag_o = (a_i > b_i);
      default: begin
        res_o  = '0;
        flag_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cioa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cioa_ctrl - arbiter sequencer
// Steps one transaction through the shared unit and raises the done strobe.
// ----------------------------------------------------------------------------
module cioa_ctrl
  import cioa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.start) begin
          case (sts_i.op)
            OP_TICK:  state_d = ST_TICK;
            OP_FRAME: state_d = ST_SCAN;
            OP_QUERY: state_d = sts_i.slot_ok ? ST_BOOT : ST_DONE;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: state_d = ST_DONE;
      ST_SCAN: begin
        if (sts_i.hit || sts_i.scan_last) state_d = ST_DONE;
      end
      ST_BOOT: state_d = ST_ELAP;
      ST_ELAP: state_d = ST_TOUT;
      ST_TOUT: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o         = '0;
    ctl_o.alu_op  = ALU_ADD;
    ctl_o.src     = SRC_TICK_ONE;
    ctl_o.busy    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: ctl_o.capture = sts_i.start;
      ST_TICK: begin
        ctl_o.alu_op  = ALU_ADD;
        ctl_o.src     = SRC_TICK_ONE;
        ctl_o.tick_we = 1'b1;
      end
      ST_SCAN: begin
        ctl_o.alu_op  = ALU_EQ;
        ctl_o.src     = SRC_ID_SCAN;
        ctl_o.scan_en = 1'b1;
      end
      ST_BOOT: begin
        ctl_o.alu_op  = ALU_LT;
        ctl_o.src     = SRC_TICK_BOOT;
        ctl_o.boot_we = 1'b1;
      end
      ST_ELAP: begin
        ctl_o.alu_op  = ALU_SUB;
        ctl_o.src     = SRC_TICK_HEARD;
        ctl_o.elap_we = 1'b1;
      end
      ST_TOUT: begin
        ctl_o.alu_op = ALU_GT;
        ctl_o.src    = SRC_ELAP_TOUT;
        ctl_o.may_we = 1'b1;
      end
      ST_DONE: ctl_o.done = 1'b1;
      default: ctl_o.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/can_id_ownership_arbiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_ownership_arbiter - CAN id ownership arbiter
// Tracks when each emulated CAN id was last heard and answers whether this
// node may transmit on it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows on rsp_o, flagged by done_o for a single cycle, and it must
// be captured then. All steps share one add/compare unit: a tick adds one to
// the time counter, a query runs the boot, elapsed and timeout steps, a frame
// compares the slot ids in turn until a hit or the last slot, and other codes
// and out-of-range queries go straight to done. busy is high from the cycle
// after acceptance through the done_o cycle. Configuration writes are taken
// at any time but are meant for idle periods.
module can_id_ownership_arbiter
  import cioa_pkg::*;
#(
  parameter int unsigned SLOTS     = 5,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Configuration registers
  mode_e              mode_q;
  logic [TICKS_W-1:0] boot_q;
  logic [TICKS_W-1:0] tout_q;
  logic [ID_W-1:0]    slot_id_q [NUM_ID_REGS];

  // Arbiter state
  logic [TIME_BITS-1:0] tick_q;
  logic [TIME_BITS-1:0] heard_time_q [SLOTS];
  logic [SLOTS-1:0]     heard_q;
  logic [SLOTS-1:0]     active_q;

  // Per-transaction working registers
  req_t                 item_q;
  logic [SLOT_W-1:0]    scan_idx_q;
  logic                 boot_lt_q;
  logic [TIME_BITS-1:0] elap_q;
  logic                 may_q;
  logic                 matched_q;
  logic [2:0]           which_q;

  ctl_t                 ctl;
  sts_t                 sts;
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
  logic                 alu_flag;
  logic [SLOT_W-1:0]    qidx;
  logic                 may_d;

  assign qidx = item_q.slot[SLOT_W-1:0];

  // Status towards the sequencer
  always_comb begin
    sts.start     = start && !busy;
    sts.op        = op_e'(req_i.op);
    sts.slot_ok   = ({29'd0, req_i.slot} < SLOTS);
    sts.scan_last = (scan_idx_q == SLOT_W'(SLOTS - 1));
    sts.hit       = alu_flag;
  end

  cioa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // Operand selection for the shared unit
  always_comb begin
    alu_a = tick_q;
    alu_b = TIME_BITS'(1);
    case (ctl.src)
      SRC_TICK_ONE: begin
        alu_a = tick_q;
        alu_b = TIME_BITS'(1);
      end
      SRC_ID_SCAN: begin
        alu_a = TIME_BITS'(slot_id_q[3'(scan_idx_q)]);
        alu_b = TIME_BITS'(item_q.can_id);
      end
      SRC_TICK_BOOT: begin
        alu_a = tick_q;
        alu_b = TIME_BITS'(boot_q);
      end
      SRC_TICK_HEARD: begin
        alu_a = tick_q;
        alu_b = heard_time_q[qidx];
      end
      SRC_ELAP_TOUT: begin
        alu_a = elap_q;
        alu_b = TIME_BITS'(tout_q);
      end
      default: begin
        alu_a = tick_q;
        alu_b = TIME_BITS'(1);
      end
    endcase
  end

  cioa_alu #(
    .W (TIME_BITS)
  ) u_alu (
    .op_i   (ctl.alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  // Transmit decision for the queried slot
  always_comb begin
    case (mode_q)
      MODE_ALWAYS: may_d = 1'b1;
      MODE_NEVER:  may_d = 1'b0;
      default:     may_d = !boot_lt_q && (!heard_q[qidx] || alu_flag);
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AUTO;
      boot_q <= BOOT_LISTEN_RESET;
      tout_q <= SILENCE_TOUT_RESET;
      for (int i = 0; i < NUM_ID_REGS; i++) slot_id_q[i] <= SLOT_ID_RESET[i];
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:  mode_q       <= mode_e'(cfg_wdata_i[1:0]);
        REG_BOOT:  boot_q       <= cfg_wdata_i;
        REG_TOUT:  tout_q       <= cfg_wdata_i;
        REG_SLOT0: slot_id_q[0] <= cfg_wdata_i[ID_W-1:0];
        REG_SLOT1: slot_id_q[1] <= cfg_wdata_i[ID_W-1:0];
        REG_SLOT2: slot_id_q[2] <= cfg_wdata_i[ID_W-1:0];
        REG_SLOT3: slot_id_q[3] <= cfg_wdata_i[ID_W-1:0];
        REG_SLOT4: slot_id_q[4] <= cfg_wdata_i[ID_W-1:0];
        default:   mode_q       <= mode_q;
      endcase
    end
  end

  // Time counter, heard flags and active mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      heard_q  <= '0;
      active_q <= '0;
      for (int i = 0; i < SLOTS; i++) heard_time_q[i] <= '0;
    end else begin
      if (ctl.tick_we) tick_q <= alu_res;
      if (ctl.scan_en && alu_flag) begin
        heard_q[scan_idx_q]      <= 1'b1;
        heard_time_q[scan_idx_q] <= tick_q;
      end
      if (ctl.may_we) active_q[qidx] <= may_d;
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q     <= '0;
      scan_idx_q <= '0;
      boot_lt_q  <= 1'b0;
      elap_q     <= '0;
      may_q      <= 1'b0;
      matched_q  <= 1'b0;
      which_q    <= '0;
    end else begin
      if (ctl.capture) begin
        item_q     <= req_i;
        scan_idx_q <= '0;
        may_q      <= 1'b0;
        matched_q  <= 1'b0;
        which_q    <= '0;
      end
      if (ctl.scan_en) begin
        if (alu_flag) begin
          matched_q <= 1'b1;
          which_q   <= 3'(scan_idx_q);
        end else if (!sts.scan_last) begin
          scan_idx_q <= scan_idx_q + SLOT_W'(1);
        end
      end
      if (ctl.boot_we) boot_lt_q <= alu_flag;
      if (ctl.elap_we) elap_q    <= alu_res;
      if (ctl.may_we)  may_q     <= may_d;
    end
  end

  // Result transaction
  assign busy   = ctl.busy;
  assign done_o = ctl.done;
  always_comb begin
    rsp_o.may_transmit = may_q;
    rsp_o.slot_matched = matched_q;
    rsp_o.matched_slot = which_q;
    rsp_o.active_mask  = 5'(active_q);
  end

endmodule
